[src/pfls_pkg.sv]
// Package for per-flow weighted link steering: request and result types,
// flow table entry layout, register indexes and protocol constants. No dependencies.
package pfls_pkg;

	localparam int NUM_LINKS    = 4;
	localparam int FLOW_ENTRIES = 64;
	localparam int IDX_W        = $clog2(FLOW_ENTRIES);
	localparam int LINK_W       = 2;
	localparam int WEIGHT_W     = 8;
	localparam int TOTAL_W      = WEIGHT_W + $clog2(NUM_LINKS);
	localparam int RND_W        = 16;
	localparam int CFG_IDX_W    = 8;
	localparam int CFG_DATA_W   = 32;

	localparam logic [CFG_IDX_W-1:0] REG_LINK_WEIGHTS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MASK  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STALE_SEC    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BYPASS_PORT  = 8'd3;

	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [7:0]  STALE_RESET    = 8'd5;
	localparam logic [15:0] BYPASS_RESET   = 16'd53;

	localparam logic [1:0] ST_CONNECTING = 2'd0;
	localparam logic [1:0] ST_CONNECTED  = 2'd1;
	localparam logic [1:0] ST_CLOSING    = 2'd2;
	localparam logic [1:0] ST_CLOSED     = 2'd3;

	typedef struct packed {
		logic        func;
		logic [63:0] dst_addr_hi;
		logic [63:0] dst_addr_lo;
		logic [63:0] src_addr_hi;
		logic [63:0] src_addr_lo;
		logic [15:0] dst_port;
		logic [15:0] src_port;
		logic [7:0]  protocol;
		logic [2:0]  tcp_flags;
		logic [15:0] random_value;
	} in_t;

	typedef struct packed {
		logic              link_valid;
		logic [LINK_W-1:0] link_index;
		logic              flow_not_stored;
	} out_t;

	typedef struct packed {
		logic [63:0]       dst_hi;
		logic [63:0]       dst_lo;
		logic [63:0]       src_hi;
		logic [63:0]       src_lo;
		logic [39:0]       ports_proto;
		logic [LINK_W-1:0] link;
		logic [1:0]        conn_state;
		logic [31:0]       last_seen;
	} entry_t;

endpackage

[src/pfls_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[src/per_flow_weighted_link_steering_top.sv]
// Top level of per-flow weighted link steering: sequencer, modulo unit,
// flow table scan and update. Depends on pfls_pkg and pfls_ram.

// Each request steers one packet to one of four links, or (func=1) advances
// the seconds counter and gives no result. A packet request is taken, then
// passes through the bit-serial modulo unit for the weighted pick (skipped
// when no active link has weight), then, for TCP flows and for UDP flows not
// sent to the bypass port, a scan of the 64-entry flow table RAM, one entry
// per cycle through its single read port, which stops at the first match;
// last the table is updated and the result posted. That last step waits while
// the result register holds a result not yet taken. A tick is done as soon as
// it is taken. in_ready is high only between requests. The result sits in an
// output register; the next request is taken while it waits. Flow valid bits
// are flip-flops cleared by reset, so no clearing pass is needed.
// Configuration writes are always accepted and must arrive while idle.
module per_flow_weighted_link_steering_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  pfls_pkg::in_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output pfls_pkg::out_t                out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pfls_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfls_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pfls_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_MOD    = 2'd1;
	localparam logic [1:0] S_SCAN   = 2'd2;
	localparam logic [1:0] S_DECIDE = 2'd3;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOW_ENTRIES - 1);
	localparam logic [3:0] MOD_LAST = 4'(RND_W - 1);

	logic [1:0] state_q;

	// configuration registers
	logic [31:0] weights_q;
	logic [NUM_LINKS-1:0] active_q;
	logic [7:0]  stale_q;
	logic [15:0] bypass_q;
	logic [31:0] seconds_q;

	// latched request
	in_t  req_q;
	logic is_udp_q, is_tcp_q;

	// modulo unit
	logic [RND_W-1:0]   div_q;
	logic [TOTAL_W-1:0] rem_q;
	logic [3:0]         mod_cnt_q;

	// scan
	logic [IDX_W-1:0] scan_cnt_q;
	logic             issue_done_q;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic             cmp_vld_s1;
	logic             found_q;
	logic [IDX_W-1:0] found_idx_q;
	entry_t           ent_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;

	logic [FLOW_ENTRIES-1:0] valid_q;

	// output register
	logic out_valid_q;
	out_t out_q;

	// RAM ports
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	entry_t           ram_rdata;

	pfls_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(FLOW_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (scan_cnt_q),
		.rdata (ram_rdata)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// total weight of active links
	logic [TOTAL_W-1:0] total;
	always_comb begin
		total = '0;
		for (int i = 0; i < NUM_LINKS; i++) begin
			if (active_q[i]) begin
				total = total + TOTAL_W'(weights_q[WEIGHT_W*i +: WEIGHT_W]);
			end
		end
	end

	// one restoring modulo step
	logic [TOTAL_W:0] mod_shift;
	logic [TOTAL_W-1:0] mod_next;
	always_comb begin
		mod_shift = {rem_q, div_q[RND_W-1]};
		if (mod_shift >= {1'b0, total}) begin
			mod_next = TOTAL_W'(mod_shift - {1'b0, total});
		end else begin
			mod_next = mod_shift[TOTAL_W-1:0];
		end
	end

	// walk links against the remainder
	logic              pick_ok;
	logic [LINK_W-1:0] pick_idx;
	always_comb begin
		logic [TOTAL_W-1:0] acc;
		acc = '0;
		pick_ok = 1'b0;
		pick_idx = '0;
		for (int i = 0; i < NUM_LINKS; i++) begin
			if (active_q[i] && !pick_ok) begin
				acc = acc + TOTAL_W'(weights_q[WEIGHT_W*i +: WEIGHT_W]);
				if (acc > rem_q) begin
					pick_ok = 1'b1;
					pick_idx = LINK_W'(i);
				end
			end
		end
		if (total == '0) begin
			pick_ok = 1'b0;
		end
	end

	// key compare for the entry in the read register
	logic [39:0] req_key;
	logic        cmp_match;
	assign req_key = {req_q.dst_port, req_q.src_port, req_q.protocol};
	assign cmp_match = cmp_vld_s1 && valid_q[cmp_idx_s1] &&
		ram_rdata.dst_hi == req_q.dst_addr_hi && ram_rdata.dst_lo == req_q.dst_addr_lo &&
		ram_rdata.src_hi == req_q.src_addr_hi && ram_rdata.src_lo == req_q.src_addr_lo &&
		ram_rdata.ports_proto == req_key;

	// table update and result
	logic              res_ok, res_ns;
	logic [LINK_W-1:0] res_link;
	logic              vclr, vset;
	logic [IDX_W-1:0]  vclr_idx;
	always_comb begin
		logic stale, have_free, do_store, ok;
		logic [IDX_W-1:0] free_sel;
		logic [LINK_W-1:0] lk;
		logic [1:0] st;
		entry_t new_ent;
		stale = 1'b0;
		have_free = free_found_q;
		free_sel = free_idx_q;
		do_store = 1'b0;
		ok = pick_ok;
		lk = pick_idx;
		st = ent_q.conn_state;
		res_ns = 1'b0;
		ram_we = 1'b0;
		ram_waddr = found_idx_q;
		ram_wdata = ent_q;
		vclr = 1'b0;
		vset = 1'b0;
		vclr_idx = found_idx_q;
		new_ent.dst_hi = req_q.dst_addr_hi;
		new_ent.dst_lo = req_q.dst_addr_lo;
		new_ent.src_hi = req_q.src_addr_hi;
		new_ent.src_lo = req_q.src_addr_lo;
		new_ent.ports_proto = req_key;
		new_ent.link = pick_idx;
		new_ent.conn_state = is_udp_q ? ST_CONNECTED : ST_CONNECTING;
		new_ent.last_seen = seconds_q;

		if (is_udp_q) begin
			stale = found_q && ((seconds_q - ent_q.last_seen) > {24'd0, stale_q});
			if (stale) begin
				vclr = 1'b1;
				have_free = 1'b1;
				if (!(free_found_q && free_idx_q < found_idx_q)) begin
					free_sel = found_idx_q;
				end
			end
			if (found_q && !stale) begin
				lk = ent_q.link;
				ok = 1'b1;
				if (!active_q[ent_q.link]) begin
					lk = pick_idx;
					ok = pick_ok;
				end
				if (ok) begin
					ram_we = 1'b1;
					ram_wdata.link = lk;
					ram_wdata.last_seen = seconds_q;
				end
			end else begin
				do_store = pick_ok;
			end
		end else if (is_tcp_q) begin
			if (found_q) begin
				lk = ent_q.link;
				ok = 1'b1;
				if (!active_q[ent_q.link]) begin
					lk = pick_idx;
					ok = pick_ok;
				end
				if (ok) begin
					if (st == ST_CONNECTING && req_q.tcp_flags[1]) begin
						st = ST_CONNECTED;
					end else if (st == ST_CLOSING && req_q.tcp_flags[1]) begin
						st = ST_CLOSED;
					end
					if (st != ST_CLOSED && req_q.tcp_flags[2]) begin
						st = ST_CLOSING;
					end
					if (st == ST_CLOSED) begin
						vclr = 1'b1;
					end else begin
						ram_we = 1'b1;
						ram_wdata.link = lk;
						ram_wdata.conn_state = st;
						ram_wdata.last_seen = seconds_q;
					end
				end
			end else begin
				do_store = pick_ok && req_q.tcp_flags[0];
			end
		end

		if (do_store) begin
			if (have_free) begin
				ram_we = 1'b1;
				ram_waddr = free_sel;
				ram_wdata = new_ent;
				vset = 1'b1;
			end else begin
				res_ns = 1'b1;
			end
		end
		res_ok = ok;
		res_link = ok ? lk : '0;
	end

	logic decide_go;
	assign decide_go = (state_q == S_DECIDE) && (!out_valid_q || out_ready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights_q <= '0;
			active_q  <= '0;
			stale_q   <= STALE_RESET;
			bypass_q  <= BYPASS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LINK_WEIGHTS: weights_q <= cfg_data;
				REG_ACTIVE_MASK:  active_q  <= cfg_data[NUM_LINKS-1:0];
				REG_STALE_SEC:    stale_q   <= cfg_data[7:0];
				REG_BYPASS_PORT:  bypass_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			seconds_q    <= '0;
			valid_q      <= '0;
			out_valid_q  <= 1'b0;
			cmp_vld_s1   <= 1'b0;
			issue_done_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (in_data.func) begin
							seconds_q <= seconds_q + 32'd1;
						end else begin
							state_q <= (total == '0) ? S_DECIDE : S_MOD;
							if ((in_data.protocol == PROTO_UDP && in_data.dst_port != bypass_q) ||
								in_data.protocol == PROTO_TCP) begin
								if (total == '0) begin
									state_q <= S_SCAN;
								end
							end
						end
					end
				end
				S_MOD: begin
					if (mod_cnt_q == MOD_LAST) begin
						state_q <= (is_udp_q || is_tcp_q) ? S_SCAN : S_DECIDE;
					end
				end
				S_SCAN: begin
					cmp_vld_s1 <= !issue_done_q;
					if (scan_cnt_q == LAST_IDX) begin
						issue_done_q <= 1'b1;
					end
					if (cmp_match || (cmp_vld_s1 && cmp_idx_s1 == LAST_IDX)) begin
						state_q <= S_DECIDE;
						cmp_vld_s1 <= 1'b0;
					end
				end
				S_DECIDE: begin
					if (decide_go) begin
						state_q <= S_IDLE;
						out_valid_q <= 1'b1;
						if (vclr) begin
							valid_q[vclr_idx] <= 1'b0;
						end
						if (vset) begin
							valid_q[ram_waddr] <= 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_IDLE) begin
				issue_done_q <= 1'b0;
				cmp_vld_s1 <= 1'b0;
			end
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q <= in_data;
				is_udp_q <= in_data.protocol == PROTO_UDP && in_data.dst_port != bypass_q;
				is_tcp_q <= in_data.protocol == PROTO_TCP;
				div_q <= in_data.random_value;
				rem_q <= '0;
				mod_cnt_q <= '0;
				scan_cnt_q <= '0;
				found_q <= 1'b0;
				found_idx_q <= '0;
				free_found_q <= 1'b0;
				free_idx_q <= '0;
			end
			S_MOD: begin
				rem_q <= mod_next;
				div_q <= {div_q[RND_W-2:0], 1'b0};
				mod_cnt_q <= mod_cnt_q + 4'd1;
			end
			S_SCAN: begin
				if (!issue_done_q) begin
					cmp_idx_s1 <= scan_cnt_q;
					if (!valid_q[scan_cnt_q] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q <= scan_cnt_q;
					end
					if (scan_cnt_q != LAST_IDX) begin
						scan_cnt_q <= scan_cnt_q + IDX_W'(1);
					end
				end
				if (cmp_match) begin
					found_q <= 1'b1;
					found_idx_q <= cmp_idx_s1;
					ent_q <= ram_rdata;
				end
			end
			default: ;
		endcase
		if (decide_go) begin
			out_q.link_valid <= res_ok;
			out_q.link_index <= res_link;
			out_q.flow_not_stored <= res_ns;
		end
	end
endmodule
